// ----- sv/mbsp_pkg.sv -----
// Package for the MIDI byte stream parser: types, byte codes and status decoders.
`default_nettype none
package mbsp_pkg;

    localparam int ByteW = 8;
    localparam int DataW = 7;
    localparam int LenW  = 28;

    localparam logic [ByteW-1:0] ChanLo      = 8'h80;
    localparam logic [ByteW-1:0] TwoHi       = 8'hBF;
    localparam logic [ByteW-1:0] OneHi       = 8'hDF;
    localparam logic [ByteW-1:0] PitchHi     = 8'hEF;
    localparam logic [ByteW-1:0] SysExStart  = 8'hF0;
    localparam logic [ByteW-1:0] TimeCode    = 8'hF1;
    localparam logic [ByteW-1:0] SongPos     = 8'hF2;
    localparam logic [ByteW-1:0] SongSel     = 8'hF3;
    localparam logic [ByteW-1:0] SysExEnd    = 8'hF7;
    localparam logic [ByteW-1:0] OneF9       = 8'hF9;
    localparam logic [ByteW-1:0] MetaStart   = 8'hFF;
    localparam logic [ByteW-1:0] DataMask    = 8'h7F;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_ONE   = 3'd1,
        MODE_TWO   = 3'd2,
        MODE_SYSEX = 3'd3,
        MODE_META  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_TWO  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [ByteW-1:0] status_byte;
        logic [DataW-1:0] first_data;
        logic [DataW-1:0] second_data;
        logic             has_second;
    } t_msg;

    function automatic logic is_two_param(input logic [ByteW-1:0] b);
        return (b >= ChanLo && b <= TwoHi) || (b > OneHi && b <= PitchHi) || b == SongPos;
    endfunction

    function automatic logic is_one_param(input logic [ByteW-1:0] b);
        return (b > TwoHi && b <= OneHi) || b == TimeCode || b == SongSel || b == OneF9;
    endfunction

endpackage
`default_nettype wire

// ----- sv/mbsp_byte_if.sv -----
// Valid/ready channels for raw MIDI bytes and for assembled messages.
`default_nettype none
interface mbsp_byte_if;
    logic                      valid;
    logic                      ready;
    logic [mbsp_pkg::ByteW-1:0] midi_byte;

    modport source (output valid, output midi_byte, input ready);
    modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mbsp_msg_if;
    logic                       valid;
    logic                       ready;
    logic [mbsp_pkg::ByteW-1:0] status_byte;
    logic [mbsp_pkg::DataW-1:0] first_data;
    logic [mbsp_pkg::DataW-1:0] second_data;
    logic                       has_second;

    modport source (output valid, output status_byte, output first_data,
                    output second_data, output has_second, input ready);
    modport sink   (input valid, input status_byte, input first_data,
                    input second_data, input has_second, output ready);
endinterface
`default_nettype wire

// ----- sv/midi_byte_stream_parser.sv -----
// MIDI byte stream parser with running status, sysex and meta event skipping.
//
//   channel  dir  payload                                        handshake
//   i_byte   in   midi_byte[7:0]                                 valid/ready
//   o_msg    out  status_byte[7:0] first_data[6:0]
//                 second_data[6:0] has_second                    valid/ready
//
// One byte is taken per cycle while input ready is high; parser state updates at the edge the byte is taken.
// A completed message is registered into the output register, or into the skid entry if that holds an untaken one.
// Output register plus one skid entry: input ready drops only when both hold messages.
// i_rst_n (synchronous) returns the parser to idle with no running status.
`default_nettype none
module midi_byte_stream_parser (
    input  wire            i_clk,
    input  wire            i_rst_n,
    mbsp_byte_if.sink      i_byte,
    mbsp_msg_if.source     o_msg
);

    mbsp_pkg::t_mode                   r_mode, n_mode;
    mbsp_pkg::t_kind                   r_kind, n_kind;
    logic [1:0]                        r_pos, n_pos;
    logic [mbsp_pkg::ByteW-1:0]        r_held_status, n_held_status;
    logic [mbsp_pkg::DataW-1:0]        r_held_first, n_held_first;
    logic [mbsp_pkg::LenW-1:0]         r_meta, n_meta;

    logic                              res_valid;
    mbsp_pkg::t_msg                    res_msg;

    logic                              r_out_valid, r_skid_valid;
    mbsp_pkg::t_msg                    r_out, r_skid;

    logic                              in_acc, out_take;
    logic [mbsp_pkg::ByteW-1:0]        b;
    logic [mbsp_pkg::LenW-1:0]         len_shift;

    assign b        = i_byte.midi_byte;
    assign in_acc   = i_byte.valid && i_byte.ready;
    assign out_take = o_msg.valid && o_msg.ready;
    assign len_shift = {r_meta[mbsp_pkg::LenW-8:0], b[mbsp_pkg::DataW-1:0]};

    // next state
    always_comb begin
        n_mode        = r_mode;
        n_kind        = r_kind;
        n_pos         = r_pos;
        n_held_status = r_held_status;
        n_held_first  = r_held_first;
        n_meta        = r_meta;
        unique case (r_mode)
            mbsp_pkg::MODE_ONE: begin
                n_mode = mbsp_pkg::MODE_IDLE;
                n_pos  = 2'd0;
                n_kind = mbsp_pkg::KIND_ONE;
            end
            mbsp_pkg::MODE_TWO: begin
                if (r_pos < 2'd2) begin
                    n_held_first = b[mbsp_pkg::DataW-1:0];
                    n_pos        = 2'd2;
                end else begin
                    n_mode = mbsp_pkg::MODE_IDLE;
                    n_pos  = 2'd0;
                    n_kind = mbsp_pkg::KIND_TWO;
                end
            end
            mbsp_pkg::MODE_SYSEX: begin
                n_kind = mbsp_pkg::KIND_NONE;
                if (b == mbsp_pkg::SysExEnd) begin
                    n_mode = mbsp_pkg::MODE_IDLE;
                    n_pos  = 2'd0;
                end
            end
            mbsp_pkg::MODE_META: begin
                if (r_pos == 2'd0) begin
                    // type byte
                    n_meta = '0;
                    n_pos  = 2'd1;
                end else if (r_pos == 2'd1) begin
                    n_meta = len_shift;
                    if (!b[mbsp_pkg::ByteW-1]) begin
                        if (len_shift == '0) begin
                            n_mode = mbsp_pkg::MODE_IDLE;
                            n_pos  = 2'd0;
                        end else begin
                            n_pos = 2'd2;
                        end
                    end
                end else begin
                    if (r_meta != '0) begin
                        n_meta = r_meta - mbsp_pkg::LenW'(1);
                    end
                    if (r_meta <= mbsp_pkg::LenW'(1)) begin
                        n_mode = mbsp_pkg::MODE_IDLE;
                        n_pos  = 2'd0;
                    end
                end
            end
            default: begin
                n_mode = mbsp_pkg::MODE_IDLE;
                n_pos  = 2'd0;
                if (mbsp_pkg::is_two_param(b)) begin
                    n_held_status = b;
                    n_mode        = mbsp_pkg::MODE_TWO;
                    n_pos         = 2'd1;
                end else if (mbsp_pkg::is_one_param(b)) begin
                    n_held_status = b;
                    n_mode        = mbsp_pkg::MODE_ONE;
                    n_pos         = 2'd1;
                end else if (!b[mbsp_pkg::ByteW-1]) begin
                    if (r_kind == mbsp_pkg::KIND_TWO) begin
                        n_held_first = b[mbsp_pkg::DataW-1:0];
                        n_mode       = mbsp_pkg::MODE_TWO;
                        n_pos        = 2'd2;
                    end
                end else if (b == mbsp_pkg::SysExStart) begin
                    n_mode = mbsp_pkg::MODE_SYSEX;
                end else if (b == mbsp_pkg::MetaStart) begin
                    n_mode = mbsp_pkg::MODE_META;
                end
            end
        endcase
    end

    // result of the current byte
    always_comb begin
        res_valid           = 1'b0;
        res_msg.status_byte = r_held_status;
        res_msg.first_data  = b[mbsp_pkg::DataW-1:0];
        res_msg.second_data = '0;
        res_msg.has_second  = 1'b0;
        unique case (r_mode)
            mbsp_pkg::MODE_ONE: begin
                res_valid = 1'b1;
            end
            mbsp_pkg::MODE_TWO: begin
                if (r_pos == 2'd2) begin
                    res_valid           = 1'b1;
                    res_msg.first_data  = r_held_first;
                    res_msg.second_data = b[mbsp_pkg::DataW-1:0];
                    res_msg.has_second  = 1'b1;
                end
            end
            mbsp_pkg::MODE_SYSEX, mbsp_pkg::MODE_META: begin
                res_valid = 1'b0;
            end
            default: begin
                // running status on a one-parameter kind completes at once
                res_valid = !b[mbsp_pkg::ByteW-1] && r_kind == mbsp_pkg::KIND_ONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= mbsp_pkg::MODE_IDLE;
            r_kind        <= mbsp_pkg::KIND_NONE;
            r_pos         <= 2'd0;
            r_held_status <= '0;
            r_held_first  <= '0;
            r_meta        <= '0;
        end else if (in_acc) begin
            r_mode        <= n_mode;
            r_kind        <= n_kind;
            r_pos         <= n_pos;
            r_held_status <= n_held_status;
            r_held_first  <= n_held_first;
            r_meta        <= n_meta;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc && res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_acc && res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= res_msg;
            end else begin
                r_skid <= res_msg;
            end
        end
    end

    assign i_byte.ready      = !r_skid_valid;
    assign o_msg.valid       = r_out_valid;
    assign o_msg.status_byte = r_out.status_byte;
    assign o_msg.first_data  = r_out.first_data;
    assign o_msg.second_data = r_out.second_data;
    assign o_msg.has_second  = r_out.has_second;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a message while output register is empty");

    a_one_param_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_mode == mbsp_pkg::MODE_ONE) |=> o_msg.valid)
        else $error("one-parameter message not presented after its data byte");

    a_single_zero_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg.valid && !o_msg.has_second) |-> (o_msg.second_data == '0))
        else $error("one-parameter message carries a second data byte");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_mode == mbsp_pkg::MODE_IDLE && !r_out_valid && !r_skid_valid))
        else $error("parser not idle after reset");

endmodule
`default_nettype wire
